### rtl/hcid_pkg.sv
// hcid_pkg: shared types and constants for the hci uart packet deframer
// no dependencies; used by the interfaces, the parser and the top level
`timescale 1ns / 1ps
`default_nettype none

package hcid_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned HPOS_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_TYPE_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIVER_ENABLE  = 2'd2;

    // configuration reset values
    localparam logic [BYTE_W-1:0] EVENT_TYPE_RST  = 8'd4;
    localparam logic [BYTE_W-1:0] DATA_TYPE_RST   = 8'd2;
    localparam logic              DELIVER_EN_RST  = 1'b1;

    // packet kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_ACL   = 1'b1;

    // last header byte of an acl data packet and the byte holding the length low half
    localparam logic [HPOS_W-1:0] HPOS_LEN_LO = 2'd2;
    localparam logic [HPOS_W-1:0] HPOS_LAST   = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_DATA_HDR = 5'b00010,
        PH_EVT_CODE = 5'b00100,
        PH_EVT_LEN  = 5'b01000,
        PH_PAYLOAD  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] event_type_code;
        logic [BYTE_W-1:0] data_type_code;
        logic              deliver_enable;
    } cfg_t;

    typedef struct packed {
        logic              emit;
        logic              packet_kind;
        logic [BYTE_W-1:0] packet_byte;
        logic              first_of_packet;
        logic              last_of_packet;
    } result_t;

endpackage

`default_nettype wire

### rtl/hcid_stream_if.sv
// hcid_rx_if and hcid_pkt_if: valid/ready channels for received bytes and packet words
// depends on hcid_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface hcid_rx_if;
    logic                          valid;
    logic                          ready;
    logic [hcid_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcid_pkt_if;
    logic                          valid;
    logic                          ready;
    logic                          packet_kind;
    logic [hcid_pkg::BYTE_W-1:0]   packet_byte;
    logic                          first_of_packet;
    logic                          last_of_packet;

    modport source (output valid, output packet_kind, output packet_byte,
                    output first_of_packet, output last_of_packet, input ready);
    modport sink   (input valid, input packet_kind, input packet_byte,
                    input first_of_packet, input last_of_packet, output ready);
endinterface

`default_nettype wire

### rtl/hcid_parser.sv
// hcid_parser: packet framing state and per-byte decode
// depends on hcid_pkg for the phase encoding, config and result structs
`timescale 1ns / 1ps
`default_nettype none

module hcid_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [hcid_pkg::BYTE_W-1:0] rx_byte,
    input  wire hcid_pkg::cfg_t              cfg,
    output hcid_pkg::result_t                res
);

    hcid_pkg::phase_t                 phase_reg, phase_next;
    logic [hcid_pkg::HPOS_W-1:0]      hpos_reg, hpos_next;
    logic [hcid_pkg::BYTE_W-1:0]      len_lo_reg, len_lo_next;
    logic [hcid_pkg::LEN_W-1:0]       remain_reg, remain_next;
    logic                             kind_reg, kind_next;
    logic [hcid_pkg::LEN_W-1:0]       remain_dec;
    logic [hcid_pkg::LEN_W-1:0]       data_len;
    logic                             emit;
    logic                             first;
    logic                             last;

    assign remain_dec = remain_reg - hcid_pkg::LEN_W'(1);
    assign data_len   = {rx_byte, len_lo_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        len_lo_next = len_lo_reg;
        remain_next = remain_reg;
        kind_next   = kind_reg;
        emit        = 1'b0;
        first       = 1'b0;
        last        = 1'b0;
        unique case (phase_reg)
            hcid_pkg::PH_DATA_HDR:
            begin
                emit  = 1'b1;
                first = (hpos_reg == '0);
                if (hpos_reg == hcid_pkg::HPOS_LEN_LO)
                begin
                    len_lo_next = rx_byte;
                end
                if (hpos_reg == hcid_pkg::HPOS_LAST)
                begin
                    remain_next = data_len;
                    hpos_next   = '0;
                    if (data_len == '0)
                    begin
                        last       = 1'b1;
                        phase_next = hcid_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = hcid_pkg::PH_PAYLOAD;
                    end
                end
                else
                begin
                    hpos_next = hpos_reg + hcid_pkg::HPOS_W'(1);
                end
            end
            hcid_pkg::PH_EVT_CODE:
            begin
                emit       = 1'b1;
                first      = 1'b1;
                phase_next = hcid_pkg::PH_EVT_LEN;
            end
            hcid_pkg::PH_EVT_LEN:
            begin
                emit        = 1'b1;
                remain_next = hcid_pkg::LEN_W'(rx_byte);
                if (rx_byte == '0)
                begin
                    last       = 1'b1;
                    phase_next = hcid_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next = hcid_pkg::PH_PAYLOAD;
                end
            end
            hcid_pkg::PH_PAYLOAD:
            begin
                emit        = 1'b1;
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    last       = 1'b1;
                    phase_next = hcid_pkg::PH_IDLE;
                end
            end
            default:
            begin
                // idle: look for a type byte, event code wins a tie
                hpos_next   = '0;
                len_lo_next = '0;
                remain_next = '0;
                if (rx_byte == cfg.event_type_code)
                begin
                    kind_next  = hcid_pkg::KIND_EVENT;
                    phase_next = hcid_pkg::PH_EVT_CODE;
                end
                else if (rx_byte == cfg.data_type_code)
                begin
                    kind_next  = hcid_pkg::KIND_ACL;
                    phase_next = hcid_pkg::PH_DATA_HDR;
                end
                else
                begin
                    phase_next = hcid_pkg::PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hcid_pkg::PH_IDLE;
            hpos_reg   <= '0;
            len_lo_reg <= '0;
            remain_reg <= '0;
            kind_reg   <= hcid_pkg::KIND_EVENT;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            len_lo_reg <= len_lo_next;
            remain_reg <= remain_next;
            kind_reg   <= kind_next;
        end
    end

    always_comb
    begin
        res.emit            = emit && cfg.deliver_enable;
        res.packet_kind     = kind_next;
        res.packet_byte     = rx_byte;
        res.first_of_packet = first;
        res.last_of_packet  = last;
    end

endmodule

`default_nettype wire

### rtl/hci_uart_packet_deframer_unit.sv
// pipeline: two register stages; a byte taken on rx is held in the input byte register,
//   then decoded and, once the output register is free, registered as a word on pkt
// throughput: one byte per cycle; rx is held off only while both the input stage
//   and the output word register are full and pkt is stalled
// type bytes, bytes between packets that match no type code and any byte taken while delivery is off produce no word
// reset (rst_n low, async) puts the parser idle, empties both stages and loads
//   the register defaults: event type 4, data type 2, delivery on
`timescale 1ns / 1ps
`default_nettype none

// top level: input byte register, framing parser, output word register, config registers
// depends on hcid_pkg, hcid_stream_if.sv and hcid_parser
module hci_uart_packet_deframer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    hcid_rx_if.sink                             rx,
    hcid_pkt_if.source                          pkt,
    input  wire logic                           cfg_write,
    input  wire logic [hcid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hcid_pkg::BYTE_W-1:0]    cfg_data
);

    // configuration registers
    hcid_pkg::cfg_t                 cfg_reg;

    // input stage
    logic                           in_valid_reg;
    logic [hcid_pkg::BYTE_W-1:0]    in_byte_reg;

    // output word register
    logic                           out_valid_reg;
    logic                           out_kind_reg;
    logic [hcid_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                           out_first_reg;
    logic                           out_last_reg;

    logic                           advance;
    logic                           step;
    logic                           rx_take;
    hcid_pkg::result_t              res;

    // the output register can load whenever it is empty or being drained
    assign advance  = !out_valid_reg || pkt.ready;
    // the input stage moves into the parser whenever the output side can take it
    assign step     = in_valid_reg && advance;
    // input stage frees up in the same cycle it hands its byte on
    assign rx.ready = !in_valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.event_type_code <= hcid_pkg::EVENT_TYPE_RST;
            cfg_reg.data_type_code  <= hcid_pkg::DATA_TYPE_RST;
            cfg_reg.deliver_enable  <= hcid_pkg::DELIVER_EN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hcid_pkg::REG_EVENT_TYPE_CODE: cfg_reg.event_type_code <= cfg_data;
                hcid_pkg::REG_DATA_TYPE_CODE:  cfg_reg.data_type_code  <= cfg_data;
                hcid_pkg::REG_DELIVER_ENABLE:  cfg_reg.deliver_enable  <= cfg_data[0];
                default:
                begin
                    // no register at this index, write is dropped
                end
            endcase
        end
    end

    // input byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // framing state and decode of the byte in the input stage
    hcid_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // output word register, loaded only for bytes that produce a word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.emit)
        begin
            out_kind_reg  <= res.packet_kind;
            out_byte_reg  <= res.packet_byte;
            out_first_reg <= res.first_of_packet;
            out_last_reg  <= res.last_of_packet;
        end
    end

    assign pkt.valid           = out_valid_reg;
    assign pkt.packet_kind     = out_kind_reg;
    assign pkt.packet_byte     = out_byte_reg;
    assign pkt.first_of_packet = out_first_reg;
    assign pkt.last_of_packet  = out_last_reg;

endmodule

`default_nettype wire

### rtl/hcid_checker.sv
// hcid_checker: port-level checks for the deframer, bound to the top level
// depends on hci_uart_packet_deframer_unit and the hcid stream interfaces
`timescale 1ns / 1ps
`default_nettype none

module hcid_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rx_valid,
    input wire logic       rx_ready,
    input wire logic       pkt_valid,
    input wire logic       pkt_ready,
    input wire logic       pkt_kind,
    input wire logic [7:0] pkt_byte,
    input wire logic       pkt_first,
    input wire logic       pkt_last
);

    // a stalled word holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt_kind) && $stable(pkt_byte)
            && $stable(pkt_first) && $stable(pkt_last))
        else $error("stalled packet word changed");

    // with nothing waiting on the output the input side is always open
    assert property (@(posedge clk) disable iff (!rst_n)
        !pkt_valid |-> rx_ready)
        else $error("rx held off while output register empty");

    // every packet has at least two bytes after the type byte
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid |-> !(pkt_first && pkt_last))
        else $error("word marked both first and last");

    // reset empties the output register
    assert property (@(posedge clk)
        !rst_n |=> !pkt_valid)
        else $error("packet word valid right after reset");

endmodule

bind hci_uart_packet_deframer_unit hcid_checker u_hcid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .pkt_valid (pkt.valid),
    .pkt_ready (pkt.ready),
    .pkt_kind  (pkt.packet_kind),
    .pkt_byte  (pkt.packet_byte),
    .pkt_first (pkt.first_of_packet),
    .pkt_last  (pkt.last_of_packet)
);

`default_nettype wire
